>>> rtl/core/sct_pkg.sv
// Shared types, constants and helper functions for the source character tokenizer.
// Holds the token kind and scanner mode enums, the keyword table and the word structs.
// Depends on nothing; every other file in rtl/core uses it.
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  // Default width of the internal line and column counters.
  localparam int POSITION_BITS_DEF = 16;

  // Width of the line and column fields on the result port.
  localparam int TOKEN_POS_BITS = 16;

  // Keyword compare window: only words of up to this many characters can match.
  localparam int KW_BYTES = 6;
  localparam int KW_BITS  = KW_BYTES * 8;
  localparam int KW_COUNT = 13;

  // Result queue sizing (power of two).
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Characters the scanner decodes.
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_DIGIT9  = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_PIPE    = 8'h7C;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  // Token kinds as they appear on the result port.
  typedef enum logic [4:0] {
    TK_INT, TK_FLOAT, TK_DOUBLE, TK_STRING, TK_BOOL, TK_CHAR, TK_IDENT, TK_NUMBER,
    TK_FLOAT_NUM, TK_IF, TK_ELSE, TK_RETURN, TK_ASSIGN, TK_PLUS, TK_MINUS, TK_STAR,
    TK_DIV, TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_SEMI, TK_GT, TK_LT,
    TK_EQ, TK_NEQ, TK_EOF, TK_WHILE, TK_FOR, TK_AND, TK_OR, TK_ERROR
  } tok_kind_t;

  // Scanner modes.
  typedef enum logic [3:0] {
    SM_IDLE, SM_WORD, SM_NUM, SM_FLOAT, SM_SLASH, SM_COMMENT,
    SM_EQ, SM_BANG, SM_AMP, SM_PIPE, SM_HALT
  } scan_mode_t;

  // One input word.
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_word_t;

  // One result word.
  typedef struct packed {
    tok_kind_t                 token_kind;
    logic [TOKEN_POS_BITS-1:0] token_line;
    logic [TOKEN_POS_BITS-1:0] token_column;
    logic [7:0]                token_length;
    logic                      last_of_run;
  } out_word_t;

  // Results produced by one accepted input word, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } emit_pair_t;

  // Keyword table. Text is right-justified: the last character sits in the low byte.
  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    "int", "float", "double", "string", "bool", "char", "if",
    "Agar", "else", "Magar", "return", "while", "for"
  };
  localparam int KW_LEN [KW_COUNT] = '{3, 5, 6, 6, 4, 4, 2, 4, 4, 5, 6, 5, 3};
  localparam tok_kind_t KW_KIND [KW_COUNT] = '{
    TK_INT, TK_FLOAT, TK_DOUBLE, TK_STRING, TK_BOOL, TK_CHAR, TK_IF,
    TK_IF, TK_ELSE, TK_ELSE, TK_RETURN, TK_WHILE, TK_FOR
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_DIGIT0) && (c <= CH_DIGIT9);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Kind of a single-character token; anything unknown is an error.
  function automatic tok_kind_t single_kind(logic [7:0] c);
    tok_kind_t k;
    k = TK_ERROR;
    case (c)
      CH_PLUS:   k = TK_PLUS;
      CH_MINUS:  k = TK_MINUS;
      CH_STAR:   k = TK_STAR;
      CH_LPAREN: k = TK_LPAREN;
      CH_RPAREN: k = TK_RPAREN;
      CH_LBRACE: k = TK_LBRACE;
      CH_RBRACE: k = TK_RBRACE;
      CH_SEMI:   k = TK_SEMI;
      CH_GT:     k = TK_GT;
      CH_LT:     k = TK_LT;
      default:   k = TK_ERROR;
    endcase
    return k;
  endfunction

  // Keyword lookup: all entries compare in parallel against the low bytes of the buffer.
  function automatic tok_kind_t word_kind(logic [KW_BITS-1:0] text, logic [7:0] len);
    tok_kind_t k;
    k = TK_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if ((len == 8'(KW_LEN[i])) &&
          ((text & ~({KW_BITS{1'b1}} << (8 * KW_LEN[i]))) == KW_TEXT[i])) begin
        k = KW_KIND[i];
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sct_scan.sv
// Scanner core: mode register, position counters, word buffer and token formation.
// Decides per accepted byte which zero, one or two tokens come out.
// Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_scan #(
  parameter int POSITION_BITS = sct_pkg::POSITION_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_fire,
  input  wire sct_pkg::in_word_t   in_word,
  output sct_pkg::emit_pair_t      emit
);

  localparam int ExtW = (POSITION_BITS > sct_pkg::TOKEN_POS_BITS) ?
                        POSITION_BITS : sct_pkg::TOKEN_POS_BITS;
  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

  sct_pkg::scan_mode_t          mode_r, mode_nxt;
  logic [sct_pkg::KW_BITS-1:0]  buf_r, buf_nxt;
  logic [7:0]                   pend_len_r, pend_len_nxt;
  logic [POSITION_BITS-1:0]     line_r, line_nxt;
  logic [POSITION_BITS-1:0]     col_r, col_nxt;
  logic [POSITION_BITS-1:0]     start_line_r, start_line_nxt;
  logic [POSITION_BITS-1:0]     start_col_r, start_col_nxt;

  // Clamp a counter value to the result field width.
  function automatic logic [sct_pkg::TOKEN_POS_BITS-1:0] clamp_pos(
    logic [POSITION_BITS-1:0] v
  );
    logic [ExtW-1:0] e;
    e = ExtW'(v);
    if (e > ExtW'({sct_pkg::TOKEN_POS_BITS{1'b1}})) begin
      return {sct_pkg::TOKEN_POS_BITS{1'b1}};
    end
    return e[sct_pkg::TOKEN_POS_BITS-1:0];
  endfunction

  // Byte classes.
  logic [7:0] ch;
  logic       eoi;
  logic       c_digit, c_alpha, c_space, c_wchar, c_dot, c_newline;
  logic       c_opener, c_single;
  assign ch        = in_word.ch;
  assign eoi       = in_word.end_of_input;
  assign c_digit   = sct_pkg::is_digit(ch);
  assign c_alpha   = sct_pkg::is_alpha(ch);
  assign c_space   = sct_pkg::is_space(ch);
  assign c_wchar   = c_digit || c_alpha || (ch == sct_pkg::CH_UNDER);
  assign c_dot     = (ch == sct_pkg::CH_DOT);
  assign c_newline = (ch == sct_pkg::CH_NEWLINE);
  assign c_opener  = (ch == sct_pkg::CH_SLASH) || (ch == sct_pkg::CH_EQUAL) ||
                     (ch == sct_pkg::CH_BANG) || (ch == sct_pkg::CH_AMP) ||
                     (ch == sct_pkg::CH_PIPE);
  assign c_single  = (sct_pkg::single_kind(ch) != sct_pkg::TK_ERROR);

  // How the current mode treats the byte.
  logic stay_word, stay_num, to_comment, stay_comment, eq_hit, pair_mode, pair_hit;
  logic absorbed, pair_done, start, has_pending, begins;
  assign stay_word    = (mode_r == sct_pkg::SM_WORD) && c_wchar;
  assign stay_num     = ((mode_r == sct_pkg::SM_NUM) || (mode_r == sct_pkg::SM_FLOAT)) &&
                        (c_digit || c_dot);
  assign to_comment   = (mode_r == sct_pkg::SM_SLASH) && (ch == sct_pkg::CH_SLASH);
  assign stay_comment = (mode_r == sct_pkg::SM_COMMENT) && !c_newline;
  assign eq_hit       = (mode_r == sct_pkg::SM_EQ) && (ch == sct_pkg::CH_EQUAL);
  assign pair_mode    = (mode_r == sct_pkg::SM_BANG) || (mode_r == sct_pkg::SM_AMP) ||
                        (mode_r == sct_pkg::SM_PIPE);
  assign pair_hit     = eq_hit ||
                        ((mode_r == sct_pkg::SM_BANG) && (ch == sct_pkg::CH_EQUAL)) ||
                        ((mode_r == sct_pkg::SM_AMP) && (ch == sct_pkg::CH_AMP)) ||
                        ((mode_r == sct_pkg::SM_PIPE) && (ch == sct_pkg::CH_PIPE));
  assign absorbed     = (mode_r == sct_pkg::SM_HALT) || stay_word || stay_num ||
                        to_comment || stay_comment;
  assign pair_done    = eq_hit || pair_mode;
  assign start        = !eoi && !absorbed && !pair_done;
  assign begins       = start && (c_digit || c_alpha || c_opener);
  assign has_pending  = (mode_r != sct_pkg::SM_IDLE) && (mode_r != sct_pkg::SM_COMMENT) &&
                        (mode_r != sct_pkg::SM_HALT);

  // Kind of the pending token when something ends it.
  sct_pkg::tok_kind_t flush_kind, pair_kind;
  always_comb begin
    unique case (mode_r)
      sct_pkg::SM_WORD:  flush_kind = sct_pkg::word_kind(buf_r, pend_len_r);
      sct_pkg::SM_NUM:   flush_kind = sct_pkg::TK_NUMBER;
      sct_pkg::SM_FLOAT: flush_kind = sct_pkg::TK_FLOAT_NUM;
      sct_pkg::SM_SLASH: flush_kind = sct_pkg::TK_DIV;
      sct_pkg::SM_EQ:    flush_kind = sct_pkg::TK_ASSIGN;
      default:           flush_kind = sct_pkg::TK_ERROR;
    endcase
  end

  always_comb begin
    unique case (mode_r)
      sct_pkg::SM_EQ:   pair_kind = sct_pkg::TK_EQ;
      sct_pkg::SM_BANG: pair_kind = sct_pkg::TK_NEQ;
      sct_pkg::SM_AMP:  pair_kind = sct_pkg::TK_AND;
      sct_pkg::SM_PIPE: pair_kind = sct_pkg::TK_OR;
      default:          pair_kind = sct_pkg::TK_ERROR;
    endcase
  end

  // Next scanner mode.
  always_comb begin
    mode_nxt = mode_r;
    if (in_fire) begin
      if (eoi) begin
        mode_nxt = sct_pkg::SM_IDLE;
      end else if (mode_r == sct_pkg::SM_HALT || stay_word) begin
        mode_nxt = mode_r;
      end else if (stay_num) begin
        mode_nxt = c_dot ? sct_pkg::SM_FLOAT : mode_r;
      end else if (to_comment || stay_comment) begin
        mode_nxt = sct_pkg::SM_COMMENT;
      end else if (pair_done) begin
        mode_nxt = pair_hit ? sct_pkg::SM_IDLE : sct_pkg::SM_HALT;
      end else if (c_space) begin
        mode_nxt = sct_pkg::SM_IDLE;
      end else if (c_digit) begin
        mode_nxt = sct_pkg::SM_NUM;
      end else if (c_alpha) begin
        mode_nxt = sct_pkg::SM_WORD;
      end else begin
        unique case (ch)
          sct_pkg::CH_SLASH: mode_nxt = sct_pkg::SM_SLASH;
          sct_pkg::CH_EQUAL: mode_nxt = sct_pkg::SM_EQ;
          sct_pkg::CH_BANG:  mode_nxt = sct_pkg::SM_BANG;
          sct_pkg::CH_AMP:   mode_nxt = sct_pkg::SM_AMP;
          sct_pkg::CH_PIPE:  mode_nxt = sct_pkg::SM_PIPE;
          default:           mode_nxt = c_single ? sct_pkg::SM_IDLE : sct_pkg::SM_HALT;
        endcase
      end
    end
  end

  // Counters, word buffer and pending length.
  always_comb begin
    line_nxt       = line_r;
    col_nxt        = col_r;
    start_line_nxt = start_line_r;
    start_col_nxt  = start_col_r;
    pend_len_nxt   = pend_len_r;
    buf_nxt        = buf_r;
    if (in_fire) begin
      if (eoi) begin
        line_nxt       = PosOne;
        col_nxt        = PosOne;
        start_line_nxt = PosOne;
        start_col_nxt  = PosOne;
        pend_len_nxt   = 8'd0;
      end else begin
        // Every byte moves the position, even in a comment or after an error.
        if (c_newline) begin
          line_nxt = (line_r == PosMax) ? line_r : line_r + PosOne;
          col_nxt  = PosOne;
        end else begin
          col_nxt = (col_r == PosMax) ? col_r : col_r + PosOne;
        end
        if (stay_word || stay_num) begin
          pend_len_nxt = (pend_len_r == 8'hFF) ? pend_len_r : pend_len_r + 8'd1;
        end else if (begins) begin
          pend_len_nxt   = 8'd1;
          start_line_nxt = line_r;
          start_col_nxt  = col_r;
        end
        // The buffer shifts left, so a short word lands right-justified.
        if ((stay_word && (pend_len_r < 8'(sct_pkg::KW_BYTES))) || (start && c_alpha)) begin
          buf_nxt = {buf_r[sct_pkg::KW_BITS-9:0], ch};
        end
      end
    end
  end

  // Tokens for this byte: the pending one it ends (a) and one it makes itself (b).
  sct_pkg::out_word_t tok_a, tok_b;
  logic               a_valid, b_valid;
  always_comb begin
    a_valid            = 1'b0;
    b_valid            = 1'b0;
    tok_a.token_kind   = flush_kind;
    tok_a.token_line   = clamp_pos(start_line_r);
    tok_a.token_column = clamp_pos(start_col_r);
    tok_a.token_length = pend_len_r;
    tok_a.last_of_run  = 1'b0;
    tok_b.token_kind   = sct_pkg::single_kind(ch);
    tok_b.token_line   = clamp_pos(line_r);
    tok_b.token_column = clamp_pos(col_r);
    tok_b.token_length = 8'd1;
    tok_b.last_of_run  = 1'b1;
    if (eoi) begin
      a_valid            = has_pending;
      b_valid            = 1'b1;
      tok_b.token_kind   = sct_pkg::TK_EOF;
      tok_b.token_length = 8'd0;
    end else if (pair_done) begin
      a_valid = 1'b1;
      if (pair_hit) begin
        tok_a.token_kind   = pair_kind;
        tok_a.token_length = 8'd2;
      end
    end else if (start) begin
      a_valid = has_pending;
      b_valid = !c_space && !c_digit && !c_alpha && !c_opener;
    end
  end

  // Order the results and mark the last one.
  always_comb begin
    emit.count              = in_fire ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
    emit.first              = a_valid ? tok_a : tok_b;
    emit.first.last_of_run  = !(a_valid && b_valid);
    emit.second             = tok_b;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= sct_pkg::SM_IDLE;
      pend_len_r   <= 8'd0;
      line_r       <= PosOne;
      col_r        <= PosOne;
      start_line_r <= PosOne;
      start_col_r  <= PosOne;
    end else begin
      mode_r       <= mode_nxt;
      pend_len_r   <= pend_len_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
      start_line_r <= start_line_nxt;
      start_col_r  <= start_col_nxt;
    end
  end

  // The word buffer has no reset; above the current word's length it may still hold older characters.
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

`ifndef SYNTHESIS
  // End of input puts the scanner back to its reset position.
  a_eoi_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && eoi) |=> (mode_r == sct_pkg::SM_IDLE && line_r == PosOne && col_r == PosOne))
    else $error("scanner not reset after end of input");

  // A halted scanner produces nothing until end of input.
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !eoi && mode_r == sct_pkg::SM_HALT) |-> (emit.count == 2'd0))
    else $error("token emitted while halted");

  // When two tokens come out, only the second one closes the run.
  a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.count == 2'd2) |-> (!emit.first.last_of_run && emit.second.last_of_run))
    else $error("wrong end-of-run marking on a token pair");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sct_result_queue.sv
// Small result queue between the scanner and the output port.
// Takes up to two tokens per cycle and hands out one per output handshake.
// Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_result_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sct_pkg::emit_pair_t  push,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sct_pkg::out_word_t        out_data
);

  sct_pkg::out_word_t             mem [sct_pkg::QUEUE_DEPTH];
  logic [sct_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [sct_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sct_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic [sct_pkg::QPTR_W-1:0]     wr_ptr_plus1;
  logic                           pop;

  // Room for a whole pair must be there before a new word is taken.
  assign room         = (count_r <= sct_pkg::QCNT_W'(sct_pkg::QUEUE_DEPTH - 2));
  assign out_valid    = (count_r != '0);
  assign out_data     = mem[rd_ptr_r];
  assign pop          = out_valid && !out_stall;
  assign wr_ptr_plus1 = wr_ptr_r + sct_pkg::QPTR_W'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + sct_pkg::QPTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + sct_pkg::QPTR_W'(pop);
    count_nxt  = count_r + sct_pkg::QCNT_W'(push.count) - sct_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; a pair goes into two neighboring slots.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_plus1] <= push.second;
    end
  end

`ifndef SYNTHESIS
  // The fill count never passes the depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sct_pkg::QCNT_W'(sct_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // Tokens arrive only when a full pair still fits.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != 2'd0) |-> room)
    else $error("tokens pushed without room");
`endif

endmodule

`default_nettype wire

>>> rtl/core/source_char_tokenizer.sv
// Top level of the source character tokenizer.
// Instantiates the scanner core and the result queue; depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexer: one source byte per input word, tokens out one per output word.
// A byte is taken in every cycle as long as the four-entry result queue has room
// for two tokens; each byte yields zero, one or two tokens (a token it ends and
// one it starts, or a pending token and EOF at end of input), so with an output
// port that never stalls the input runs at one byte per cycle unless a stretch of
// text makes more than one token per byte, in which case the output port, one
// token per cycle, sets the pace. A token leaves the queue at the earliest in the
// cycle after the byte that completes it is accepted; a word, a number, a lone /
// and a lone = are completed only by the byte that follows them or by end of
// input. Line and column count from one; counters
// are POSITION_BITS wide and saturate, the result fields clamp at 65535. After a
// bad character the block drops bytes until end of input, which flushes any
// pending token, emits EOF and returns the block to its reset state.
module source_char_tokenizer #(
  parameter int POSITION_BITS = sct_pkg::POSITION_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sct_pkg::in_word_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sct_pkg::out_word_t       out_data
);

  logic                in_fire;
  logic                room;
  sct_pkg::emit_pair_t emit;

  // Input handshake.
  assign in_stall = !room;
  assign in_fire  = in_valid && room;

  sct_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_word (in_data),
    .emit    (emit)
  );

  sct_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
